FILE: hw/rtl/double_ended_queue_defines.svh
// Assertion macros used by the RTL. Both expect clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define DEQ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication.
`define DEQ_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

FILE: hw/rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

endpackage

FILE: hw/rtl/deq_req_if.sv
interface deq_req_if import deq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic        [OP_W-1:0]   operation;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);

endinterface

FILE: hw/rtl/deq_rsp_if.sv
interface deq_rsp_if import deq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] word;
    logic        [STATUS_W-1:0] status;
    logic                     now_empty;

    modport source (output valid, output word, output status, output now_empty, input ready);
    modport sink   (input valid, input word, input status, input now_empty, output ready);

endinterface

FILE: hw/rtl/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Channel | Dir | Payload                   | Transaction
// req     | in  | operation, value          | valid && ready at rising clk
// rsp     | out | word, status, now_empty   | valid && ready at rising clk
//
// One request per cycle unless stalled; responses go via s1 and out regs.
// Front index and occupancy update in the accept cycle; the ring memory is
// read or written there, and its registered read data forms the response.
// Reset clears indices, valid bits; ring entries undefined until pushed.
// A held response stalls the read stage, and req.ready drops with it.
`include "double_ended_queue_defines.svh"

module double_ended_queue import deq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic   clk,
    input  logic   rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    typedef struct packed {
        logic                use_rd;
        logic                underflow;
        logic [STATUS_W-1:0] status;
        logic                now_empty;
    } stage_t;

    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic              s1_valid_reg, s1_valid_next;
    stage_t            s1_reg, s1_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [WORD_W-1:0] out_word_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic                     out_empty_reg;

    logic              acc;
    logic              s1_adv;
    logic              empty;
    logic              full;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] tail_addr;
    logic [ADDR_W-1:0] rear_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign acc       = req.valid && req.ready;

    assign empty     = (occ_reg == '0);
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign head_dec  = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc  = ring_add(head_reg, CNT_W'(1));
    assign tail_addr = ring_add(head_reg, occ_reg);
    assign rear_addr = ring_add(head_reg, occ_reg - 1'b1);

    always_comb
    begin
        head_next        = head_reg;
        occ_next         = occ_reg;
        ram_we           = 1'b0;
        ram_waddr        = tail_addr;
        ram_re           = 1'b0;
        ram_raddr        = head_reg;
        s1_next.use_rd    = 1'b0;
        s1_next.underflow = 1'b0;
        s1_next.status    = STATUS_OK;
        if (acc)
        begin
            case (req.operation)
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        s1_next.status = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        occ_next = occ_reg + 1'b1;
                        if (req.operation == OP_PUSH_FRONT)
                        begin
                            head_next = head_dec;
                            ram_waddr = head_dec;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR:
                begin
                    if (empty)
                    begin
                        s1_next.status    = STATUS_UNDERFLOW;
                        s1_next.underflow = 1'b1;
                    end
                    else
                    begin
                        ram_re         = 1'b1;
                        s1_next.use_rd = 1'b1;
                        ram_raddr = (req.operation inside {OP_POP_FRONT, OP_PEEK_FRONT})
                                    ? head_reg : rear_addr;
                        if (req.operation == OP_POP_FRONT)
                        begin
                            head_next = head_inc;
                            occ_next  = occ_reg - 1'b1;
                        end
                        else if (req.operation == OP_POP_REAR)
                        begin
                            occ_next = occ_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        s1_next.now_empty = (occ_next == '0);
    end

    always_comb
    begin
        s1_valid_next = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_word_reg   <= s1_reg.underflow ? {WORD_W{1'b1}}
                            : (s1_reg.use_rd ? ram_rdata : '0);
            out_status_reg <= s1_reg.status;
            out_empty_reg  <= s1_reg.now_empty;
        end
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp.valid     = out_valid_reg;
    assign rsp.word      = out_word_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.now_empty = out_empty_reg;

    `DEQ_ASSERT_NXT(a_full_push_holds,
        acc && full && (req.operation == OP_PUSH_FRONT || req.operation == OP_PUSH_REAR),
        $stable(occ_reg) && $stable(head_reg))
    `DEQ_ASSERT_NXT(a_push_grows,
        acc && !full && (req.operation == OP_PUSH_FRONT || req.operation == OP_PUSH_REAR),
        occ_reg == $past(occ_reg) + 1'b1)
    `DEQ_ASSERT_IMP(a_underflow_word,
        rsp.valid && rsp.status == STATUS_UNDERFLOW,
        rsp.word == {WORD_W{1'b1}})
    `DEQ_ASSERT_IMP(a_stall_blocks_req,
        s1_valid_reg && out_valid_reg && !rsp.ready,
        !req.ready)
    `DEQ_ASSERT_IMP(a_occ_bound,
        1'b1,
        occ_reg <= CNT_W'(DEPTH))

endmodule
